// ----- hw/rtl/lmc_pkg.sv -----
// lmc_pkg: shared widths, window geometry and job types for the local maximum counter
// no dependencies; used by every module of the block except lmc_fifo
`timescale 1ns / 1ps

package lmc_pkg;

   localparam int PIX_W         = 32;
   localparam int SIZE_W        = 7;
   localparam int CNT_W         = 13;
   localparam int MAX_SIZE_DEF  = 64;
   localparam int JOB_DEPTH_DEF = 2;
   localparam int RSP_DEPTH_DEF = 2;

   localparam int WIN_CELLS = 9;
   localparam int NUM_DIRS  = 8;
   localparam int NUM_CTRS  = 4;

   // neighbour offsets, row then column
   localparam int ROW_STEP [NUM_DIRS] = '{-1, -1, -1, 0, 0, 1, 1, 1};
   localparam int COL_STEP [NUM_DIRS] = '{-1, 0, 1, -1, 1, -1, 0, 1};

   // window positions of the elements that may be judged on one beat
   localparam int CTR_ROW [NUM_CTRS] = '{1, 1, 2, 2};
   localparam int CTR_COL [NUM_CTRS] = '{1, 2, 1, 2};

   // where the newest element sits in its matrix
   typedef struct packed {
      logic up1;       // row >= 1
      logic up2;       // row >= 2
      logic left1;     // col >= 1
      logic left2;     // col >= 2
      logic col_last;  // last column
      logic row_last;  // last row
   } pos_type;

   typedef struct packed {
      logic [WIN_CELLS-1:0][PIX_W-1:0] win;
      pos_type                          pos;
   } job_type;

   typedef logic [NUM_CTRS-1:0][NUM_DIRS-1:0] lt_type;

   // neighbours of a window centre that lie inside the matrix
   function automatic logic [NUM_DIRS-1:0] nbr_mask(input int ci, input pos_type pos);
      logic [NUM_DIRS-1:0] m;
      logic                ok;
      m = '0;
      for (int k = 0; k < NUM_DIRS; k++) begin
         ok = 1'b1;
         if (ROW_STEP[k] < 0) ok = ok & ((CTR_ROW[ci] == 1) ? pos.up2 : pos.up1);
         if (ROW_STEP[k] > 0) ok = ok & (CTR_ROW[ci] == 1);
         if (COL_STEP[k] < 0) ok = ok & ((CTR_COL[ci] == 1) ? pos.left2 : pos.left1);
         if (COL_STEP[k] > 0) ok = ok & (CTR_COL[ci] == 1);
         m[k] = ok;
      end
      return m;
   endfunction

   // whether a window centre is judged on this beat
   function automatic logic ctr_enable(input int ci, input pos_type pos);
      logic en;
      case (ci)
         0: begin
            en = pos.up1 & pos.left1;
         end
         1: begin
            en = pos.up1 & pos.col_last;
         end
         2: begin
            en = pos.row_last & pos.left1;
         end
         3: begin
            en = pos.row_last & pos.col_last;
         end
         default: begin
            en = 1'b0;
         end
      endcase
      return en;
   endfunction

endpackage

// ----- hw/rtl/lmc_fifo.sv -----
// lmc_fifo: small first-in first-out queue with full and empty flags
// standalone; width and depth come from the instantiating module
`timescale 1ns / 1ps

module lmc_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
   localparam logic [CW-1:0] DEPTH_V  = CW'(DEPTH);

   logic [WIDTH-1:0] data_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == DEPTH_V);
   assign empty    = (count_ff == '0);
   assign do_push  = push & ~full;
   assign do_pop   = pop & ~empty;
   assign pop_data = data_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      if (do_pop)  rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      if (do_push && !do_pop) count_in = count_ff + 1'b1;
      if (do_pop && !do_push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) data_ff[wr_ptr_ff] <= push_data;
   end

endmodule

// ----- hw/rtl/lmc_front.sv -----
// lmc_front: takes matrix elements, tracks position, keeps both line stores and the window
// depends on lmc_pkg; hands one window job per element to the job queue
`timescale 1ns / 1ps

module lmc_front #(
   parameter int MAX_SIZE = lmc_pkg::MAX_SIZE_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          cfg_write,
   input  logic [lmc_pkg::SIZE_W-1:0]    cfg_size,
   input  logic                          push,
   output logic                          full,
   input  logic [lmc_pkg::PIX_W-1:0]     pixel,
   input  logic                          job_full,
   output logic                          job_push,
   output lmc_pkg::job_type              job_data
);

   import lmc_pkg::*;

   localparam int AW   = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
   localparam int NMAX = (MAX_SIZE < (2**SIZE_W - 1)) ? MAX_SIZE : (2**SIZE_W - 1);
   localparam logic [SIZE_W-1:0] NMAX_V = SIZE_W'(NMAX);

   logic [PIX_W-1:0] upper_line_mem  [MAX_SIZE];
   logic [PIX_W-1:0] middle_line_mem [MAX_SIZE];

   logic [SIZE_W-1:0] last_ff, last_in;
   logic [SIZE_W-1:0] col_ff, col_in;
   logic [SIZE_W-1:0] row_ff, row_in;

   // read stage
   logic              a_valid_ff, a_valid_in;
   logic [PIX_W-1:0]  a_pix_ff;
   logic [AW-1:0]     a_addr_ff;
   pos_type           a_pos_ff;
   logic [PIX_W-1:0]  upper_rd_ff;
   logic [PIX_W-1:0]  middle_rd_ff;

   logic [WIN_CELLS-1:0][PIX_W-1:0] window_ff, window_in;

   logic              accept, advance;
   logic [AW-1:0]     addr;
   logic [SIZE_W-1:0] size_clamped;
   pos_type           pos_now;

   assign advance  = a_valid_ff & ~job_full;
   assign full     = a_valid_ff & job_full;
   assign accept   = push & ~full;
   assign addr     = AW'(col_ff);
   assign job_push = advance;

   always_comb begin
      if (cfg_size == '0) begin
         size_clamped = SIZE_W'(1);
      end else if (cfg_size > NMAX_V) begin
         size_clamped = NMAX_V;
      end else begin
         size_clamped = cfg_size;
      end
   end

   always_comb begin
      pos_now.up1      = (row_ff != '0);
      pos_now.up2      = (row_ff >= SIZE_W'(2));
      pos_now.left1    = (col_ff != '0);
      pos_now.left2    = (col_ff >= SIZE_W'(2));
      pos_now.col_last = (col_ff == last_ff);
      pos_now.row_last = (row_ff == last_ff);
   end

   // raster position
   always_comb begin
      last_in    = last_ff;
      col_in     = col_ff;
      row_in     = row_ff;
      a_valid_in = a_valid_ff;
      if (advance) a_valid_in = 1'b0;
      if (accept) begin
         a_valid_in = 1'b1;
         if (pos_now.col_last) begin
            col_in = '0;
            row_in = pos_now.row_last ? '0 : row_ff + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
      if (cfg_write) begin
         last_in = size_clamped - 1'b1;
         col_in  = '0;
         row_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff    <= '0;
         col_ff     <= '0;
         row_ff     <= '0;
         a_valid_ff <= 1'b0;
      end else begin
         last_ff    <= last_in;
         col_ff     <= col_in;
         row_ff     <= row_in;
         a_valid_ff <= a_valid_in;
      end
   end

   // line stores: middle written on accept, upper written when the beat moves on
   always_ff @(posedge clock) begin
      if (accept) begin
         upper_rd_ff            <= upper_line_mem[addr];
         middle_rd_ff           <= middle_line_mem[addr];
         middle_line_mem[addr]  <= pixel;
         a_pix_ff               <= pixel;
         a_addr_ff              <= addr;
         a_pos_ff               <= pos_now;
      end
      if (advance) upper_line_mem[a_addr_ff] <= middle_rd_ff;
   end

   // window shifts left by one column per element
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         window_in[i*3 + 0] = window_ff[i*3 + 1];
         window_in[i*3 + 1] = window_ff[i*3 + 2];
      end
      window_in[2] = upper_rd_ff;
      window_in[5] = middle_rd_ff;
      window_in[8] = a_pix_ff;
   end

   always_ff @(posedge clock) begin
      if (advance) window_ff <= window_in;
   end

   assign job_data.win = window_in;
   assign job_data.pos = a_pos_ff;

endmodule

// ----- hw/rtl/lmc_back.sv -----
// lmc_back: compares each window centre with its neighbours and keeps the matrix count
// depends on lmc_pkg; reads window jobs, writes counts to the result queue
`timescale 1ns / 1ps

module lmc_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        cfg_clear,
   input  logic                        job_empty,
   input  lmc_pkg::job_type            job_data,
   output logic                        job_pop,
   input  logic                        res_full,
   output logic                        res_push,
   output logic [lmc_pkg::CNT_W-1:0]   res_count
);

   import lmc_pkg::*;

   lt_type     lt_now;
   logic       b1_valid_ff, b1_valid_in;
   lt_type     b1_lt_ff;
   pos_type    b1_pos_ff;
   logic [CNT_W-1:0] total_ff, total_in;

   logic [NUM_CTRS-1:0] judged;
   logic [2:0]          add;
   logic [CNT_W-1:0]    total_sum;
   logic                b1_last, b1_adv;

   // centre strictly below a neighbour; only neighbours inside the window exist
   for (genvar ci = 0; ci < NUM_CTRS; ci++) begin : g_ctr
      for (genvar k = 0; k < NUM_DIRS; k++) begin : g_dir
         localparam int PR = CTR_ROW[ci] + ROW_STEP[k];
         localparam int PC = CTR_COL[ci] + COL_STEP[k];
         if (PR <= 2 && PC <= 2) begin : g_in
            assign lt_now[ci][k] = $signed(job_data.win[CTR_ROW[ci]*3 + CTR_COL[ci]])
                                 < $signed(job_data.win[PR*3 + PC]);
         end else begin : g_out
            assign lt_now[ci][k] = 1'b0;
         end
      end
   end

   assign b1_last  = b1_pos_ff.row_last & b1_pos_ff.col_last;
   assign b1_adv   = b1_valid_ff & (~b1_last | ~res_full);
   assign job_pop  = ~job_empty & (~b1_valid_ff | b1_adv);

   always_comb begin
      add = '0;
      for (int ci = 0; ci < NUM_CTRS; ci++) begin
         judged[ci] = ctr_enable(ci, b1_pos_ff)
                    & ~|(b1_lt_ff[ci] & nbr_mask(ci, b1_pos_ff));
         add = add + 3'(judged[ci]);
      end
   end

   assign total_sum = total_ff + CNT_W'(add);
   assign res_push  = b1_adv & b1_last;
   assign res_count = total_sum;

   always_comb begin
      b1_valid_in = b1_valid_ff;
      total_in    = total_ff;
      if (!b1_valid_ff || b1_adv) b1_valid_in = job_pop;
      if (b1_adv) total_in = b1_last ? '0 : total_sum;
      if (cfg_clear) total_in = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_valid_ff <= 1'b0;
         total_ff    <= '0;
      end else begin
         b1_valid_ff <= b1_valid_in;
         total_ff    <= total_in;
      end
   end

   always_ff @(posedge clock) begin
      if (job_pop) begin
         b1_lt_ff  <= lt_now;
         b1_pos_ff <= job_data.pos;
      end
   end

endmodule

// ----- hw/rtl/local_maximum_counter.sv -----
// local_maximum_counter: top level of the eight-neighbour local maximum counter
// depends on lmc_pkg, lmc_fifo, lmc_front and lmc_back
`timescale 1ns / 1ps

// usage
// - csr channel: csr_matrix_size sets the side n of the square matrix (0 acts as 1,
//   values above MAX_SIZE act as MAX_SIZE); a write also drops any matrix in progress.
//   csr_ready is always high; write only while the block is drained
// - request side is a queue input: a beat is taken when push is high and full is low,
//   one matrix element per beat in row-major order
// - response side is a queue output: while empty is low the count of the oldest finished
//   matrix is on rsp_local_max_count, and pop takes it
// - one element per clock sustained; full rises only when the job queue between the
//   front end and the compare back end has no room
// - after the last element of a matrix is taken, its count passes the read stage, the job
//   queue, the compare register and the response queue; then the block is drained
// - the front end reads both line stores on accept and retires the window when the job
//   queue has room; back end registers 21 neighbour compares, then adds up to four hits
// - if pop stalls, counts wait in the response queue and elements keep flowing until the
//   job queue fills; nothing is dropped
// - reset empties both queues and returns to the first element of a 1 by 1 matrix;
//   line store contents are not cleared, entries are always written before use

module local_maximum_counter #(
   parameter int MAX_SIZE  = lmc_pkg::MAX_SIZE_DEF,
   parameter int JOB_DEPTH = lmc_pkg::JOB_DEPTH_DEF,
   parameter int RSP_DEPTH = lmc_pkg::RSP_DEPTH_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [lmc_pkg::SIZE_W-1:0]  csr_matrix_size,
   input  logic                        push,
   output logic                        full,
   input  logic [lmc_pkg::PIX_W-1:0]   req_pixel_value,
   output logic                        empty,
   input  logic                        pop,
   output logic [lmc_pkg::CNT_W-1:0]   rsp_local_max_count
);

   import lmc_pkg::*;

   logic             cfg_write;
   logic             job_push, job_full, job_pop, job_empty;
   job_type          job_in, job_out;
   logic             res_push, res_full;
   logic [CNT_W-1:0] res_count;

   // config writes are accepted at any time
   assign csr_ready = 1'b1;
   assign cfg_write = csr_valid & csr_ready;

   // front end: position tracking, line stores and the 3 by 3 window
   lmc_front #(
      .MAX_SIZE (MAX_SIZE)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .cfg_write(cfg_write),
      .cfg_size (csr_matrix_size),
      .push     (push),
      .full     (full),
      .pixel    (req_pixel_value),
      .job_full (job_full),
      .job_push (job_push),
      .job_data (job_in)
   );

   // short queue that decouples the front end from the compare back end
   lmc_fifo #(
      .WIDTH($bits(job_type)),
      .DEPTH(JOB_DEPTH)
   ) u_job_q (
      .clock    (clock),
      .reset    (reset),
      .push     (job_push),
      .push_data(job_in),
      .full     (job_full),
      .pop      (job_pop),
      .pop_data (job_out),
      .empty    (job_empty)
   );

   // back end: neighbour compares and the running count
   lmc_back u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg_clear(cfg_write),
      .job_empty(job_empty),
      .job_data (job_out),
      .job_pop  (job_pop),
      .res_full (res_full),
      .res_push (res_push),
      .res_count(res_count)
   );

   // finished counts wait here for the consumer
   lmc_fifo #(
      .WIDTH(CNT_W),
      .DEPTH(RSP_DEPTH)
   ) u_rsp_q (
      .clock    (clock),
      .reset    (reset),
      .push     (res_push),
      .push_data(res_count),
      .full     (res_full),
      .pop      (pop),
      .pop_data (rsp_local_max_count),
      .empty    (empty)
   );

   // an accepted beat either leaves the read stage next cycle or holds it stalled
   a_beat_moves: assert property (@(posedge clock) disable iff (reset)
      (push && !full) |=> (job_push || full))
      else $error("accepted beat neither retired nor stalled");

   // the back end never pushes a count into a full response queue
   a_no_rsp_overflow: assert property (@(posedge clock) disable iff (reset)
      res_push |-> !res_full)
      else $error("count pushed into full response queue");

   // a count only becomes visible after the back end produced one
   a_rsp_from_back: assert property (@(posedge clock) disable iff (reset)
      $fell(empty) |-> $past(res_push))
      else $error("response appeared without a count from the back end");

endmodule

// ----- sim/tb_local_maximum_counter.sv -----
// tb_local_maximum_counter: self-checking bench for the local maximum counter
// depends on lmc_pkg and local_maximum_counter; the bench keeps its own copy of each
// matrix, counts the peaks when the last element goes in and checks every count popped
`timescale 1ns / 1ps

typedef logic signed [lmc_pkg::PIX_W-1:0] pixel_type;
typedef logic [lmc_pkg::CNT_W-1:0]        count_type;
typedef logic [lmc_pkg::SIZE_W-1:0]       side_type;

// keeps the matrix in progress and the counts still owed by the block
class max_count_board;
   side_type   side_reg;
   pixel_type  grid[$];
   count_type  counts_due[$];
   int         errors;

   function new();
      side_reg = side_type'(1);
      errors   = 0;
   endfunction

   // 0 acts as 1, anything past the line store depth acts as the depth
   function int active_side();
      if (side_reg == 0) return 1;
      if (side_reg > lmc_pkg::MAX_SIZE_DEF) return lmc_pkg::MAX_SIZE_DEF;
      return int'(side_reg);
   endfunction

   // a size write drops whatever part of a matrix was already sent
   function void write_side(input side_type v);
      side_reg = v;
      grid.delete();
   endfunction

   // a peak has no neighbour inside the matrix that is strictly greater
   function count_type count_peaks(input int n);
      count_type total;
      bit        peak;
      int        nr;
      int        nc;
      total = '0;
      for (int r = 0; r < n; r++) begin
         for (int c = 0; c < n; c++) begin
            peak = 1'b1;
            for (int dr = -1; dr <= 1; dr++) begin
               for (int dc = -1; dc <= 1; dc++) begin
                  nr = r + dr;
                  nc = c + dc;
                  if ((dr != 0 || dc != 0) && nr >= 0 && nr < n && nc >= 0 && nc < n
                      && grid[nr * n + nc] > grid[r * n + c])
                     peak = 1'b0;
               end
            end
            if (peak) total++;
         end
      end
      return total;
   endfunction

   function void note_pixel(input pixel_type px);
      int n;
      n = active_side();
      grid.push_back(px);
      if (grid.size() == n * n) begin
         counts_due.push_back(count_peaks(n));
         grid.delete();
      end
   endfunction

   function void check_count(input count_type got);
      count_type want;
      if (counts_due.size() == 0) begin
         $display("%0t: local_max_count %0d popped with no count owed", $time, got);
         errors++;
         return;
      end
      want = counts_due.pop_front();
      if (got !== want) begin
         $display("%0t: local_max_count mismatch, expected %0d, actual %0d",
                  $time, want, got);
         errors++;
      end
   endfunction

   function int pending();
      return counts_due.size();
   endfunction
endclass

module tb_local_maximum_counter;

   localparam int CYCLE_LIMIT   = 1000000;
   localparam int TOTAL_PIXELS  = 1800;
   localparam int CALM_SIDE     = 24;
   localparam int DRAIN_CYCLES  = 8;
   localparam int IDLE_PCT      = 21;
   localparam pixel_type PIX_MAX = 32'sh7fff_ffff;
   localparam pixel_type PIX_MIN = 32'sh8000_0000;

   typedef enum int {FILL_FULL, FILL_TIES, FILL_SIGN, FILL_EXTREME} fill_style_type;

   logic      clock;
   logic      reset;
   logic      csr_valid;
   logic      csr_ready;
   side_type  csr_matrix_size;
   logic      push;
   logic      full;
   pixel_type req_pixel_value;
   logic      empty;
   logic      pop;
   count_type rsp_local_max_count;

   max_count_board board = new();
   bit calm;              // no idling on either side while set
   int rsp_hold;          // cycles the response side still holds pop low
   int cycle_count;
   int pixels_sent;

   local_maximum_counter u_dut (
      .clock               (clock),
      .reset               (reset),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_matrix_size     (csr_matrix_size),
      .push                (push),
      .full                (full),
      .req_pixel_value     (req_pixel_value),
      .empty               (empty),
      .pop                 (pop),
      .rsp_local_max_count (rsp_local_max_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // response side: check at the edge, then choose pop for the next one
   initial begin : rsp_side
      pop = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && pop && !empty) board.check_count(rsp_local_max_count);
         if (rsp_hold > 0) begin
            rsp_hold--;
            pop <= 1'b0;
         end else begin
            pop <= calm || ($urandom_range(99) >= IDLE_PCT);
         end
      end
   end

   initial begin : watchdog
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("local_maximum_counter test failed");
      $finish;
   end

   function automatic pixel_type rand_pixel(input fill_style_type style);
      pixel_type v;
      case (style)
         FILL_TIES: begin
            v = pixel_type'($urandom_range(3));
         end
         FILL_SIGN: begin
            v = pixel_type'($urandom_range(3)) - 2;
         end
         FILL_EXTREME: begin
            case ($urandom_range(3))
               0: v = PIX_MIN;
               1: v = PIX_MAX;
               2: v = -1;
               default: v = 0;
            endcase
         end
         default: begin
            v = pixel_type'($urandom);
         end
      endcase
      return v;
   endfunction

   // one beat on the request side; push stays high if the next beat follows at once
   task automatic send_pixel(input pixel_type v);
      while (!calm && $urandom_range(99) < IDLE_PCT) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push            <= 1'b1;
      req_pixel_value <= v;
      do @(posedge clock); while (full);
      board.note_pixel(v);
      pixels_sent++;
   endtask

   task automatic send_run(input int count, input fill_style_type style);
      for (int i = 0; i < count; i++) send_pixel(rand_pixel(style));
   endtask

   // all counts popped, then enough cycles for a half-sent matrix to settle
   task automatic wait_drained();
      push <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_side(input side_type v);
      wait_drained();
      csr_valid       <= 1'b1;
      csr_matrix_size <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      board.write_side(v);
   endtask

   initial begin : stimulus
      int             n;
      int             pick;
      side_type       side;
      fill_style_type style;

      reset           = 1'b1;
      csr_valid       = 1'b0;
      csr_matrix_size = '0;
      push            = 1'b0;
      req_pixel_value = '0;
      calm            = 1'b0;
      rsp_hold        = 0;
      pixels_sent     = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // size left at its reset value of 1
      send_pixel(PIX_MAX);
      // size 0 acts as 1
      write_side(side_type'(0));
      send_pixel(PIX_MIN);
      // 2 by 2 with both extremes, only the corner holding the max counts
      write_side(side_type'(2));
      send_pixel(PIX_MAX);
      send_pixel(PIX_MIN);
      send_pixel(-1);
      send_pixel(0);
      // flat 3 by 3, ties count everywhere
      write_side(side_type'(3));
      for (int i = 0; i < 9; i++) send_pixel(5);
      // half a matrix, then a size write abandons it
      write_side(side_type'(3));
      send_run(4, FILL_FULL);
      write_side(side_type'(2));
      send_pixel(-1);
      send_pixel(-1);
      send_pixel(-2);
      send_pixel(-1);

      // pop held off while 1 by 1 matrices keep coming, so full must rise
      write_side(side_type'(1));
      rsp_hold = 300;
      send_run(40, FILL_FULL);

      // oversize acts as 64: three rows and a bit, then abandoned
      write_side(side_type'(127));
      send_run(3 * lmc_pkg::MAX_SIZE_DEF + 5, FILL_TIES);
      // one full 24 by 24 matrix with no idling at all
      write_side(side_type'(CALM_SIDE));
      calm = 1'b1;
      send_run(CALM_SIDE * CALM_SIDE, FILL_TIES);
      wait_drained();
      calm = 1'b0;

      // random phases: mostly small matrices back to back, now and then a broken one
      while (pixels_sent < TOTAL_PIXELS) begin
         pick = $urandom_range(99);
         if (pick < 5) side = side_type'(0);
         else if (pick < 80) side = side_type'($urandom_range(8, 1));
         else side = side_type'($urandom_range(20, 9));
         write_side(side);
         n = board.active_side();
         repeat ($urandom_range(4, 1)) begin
            style = fill_style_type'($urandom_range(3));
            if (pixels_sent < TOTAL_PIXELS) send_run(n * n, style);
         end
         if (n > 1 && $urandom_range(99) < 12)
            send_run($urandom_range(n * n - 1, 1), fill_style_type'($urandom_range(3)));
      end

      wait_drained();
      if (board.errors == 0 && board.pending() == 0) begin
         $display("local_maximum_counter test passed");
      end else begin
         $display("local_maximum_counter test failed");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
hw/rtl/lmc_pkg.sv
hw/rtl/lmc_fifo.sv
hw/rtl/lmc_front.sv
hw/rtl/lmc_back.sv
hw/rtl/local_maximum_counter.sv
sim/tb_local_maximum_counter.sv
